FILE: hw/rtl/s2d_pkg.sv
// ----------------------------------------------------------------------------
// s2d_pkg
// Shared constants for the signed binary to decimal text converter.
// ----------------------------------------------------------------------------
`default_nettype none

package s2d_pkg;

  // width of one text character and of the byte that carries it
  localparam int unsigned CHAR_W     = 7;
  localparam int unsigned OUT_DATA_W = 8;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'd48;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'd45;

endpackage : s2d_pkg

`default_nettype wire

FILE: hw/rtl/s2d_front.sv
// ----------------------------------------------------------------------------
// s2d_front
// Takes in requests, splits each value into sign and magnitude, and holds
// them in a two-entry queue ahead of the conversion engine.
// ----------------------------------------------------------------------------
`default_nettype none

module s2d_front #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [VALUE_BITS-1:0] value_i,
  output logic                       item_valid_o,
  input  wire logic                  item_ready_i,
  output logic                       item_neg_o,
  output logic      [VALUE_BITS-1:0] item_mag_o
);
  import s2d_pkg::*;

  localparam int unsigned DEPTH = 2;

  logic                  neg;
  logic [VALUE_BITS-1:0] mag;
  logic                  push;
  logic                  pop;

  logic                  neg_q [DEPTH];
  logic [VALUE_BITS-1:0] mag_q [DEPTH];
  logic                  wr_ptr_q;
  logic                  wr_ptr_d;
  logic                  rd_ptr_q;
  logic                  rd_ptr_d;
  logic [1:0]            count_q;
  logic [1:0]            count_d;

  // magnitude by two's complement negation; the most negative value maps to
  // 2^(VALUE_BITS-1) as an unsigned number
  assign neg = value_i[VALUE_BITS-1];
  assign mag = neg ? VALUE_BITS'(~value_i + VALUE_BITS'(1)) : value_i;

  assign in_ready_o   = (count_q != 2'(DEPTH));
  assign push         = in_valid_i && in_ready_o;
  assign item_valid_o = (count_q != 2'd0);
  assign pop          = item_valid_o && item_ready_i;
  assign item_neg_o   = neg_q[rd_ptr_q];
  assign item_mag_o   = mag_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      neg_q[wr_ptr_q] <= neg;
      mag_q[wr_ptr_q] <= mag;
    end
  end

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 2'(DEPTH))
    else $error("queue count beyond depth");

  a_ptr_gap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd1) |-> (wr_ptr_q != rd_ptr_q))
    else $error("pointers disagree with one entry held");

  a_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + 2'd1))
    else $error("queue count missed a push");

endmodule : s2d_front

`default_nettype wire

FILE: hw/rtl/s2d_back.sv
// ----------------------------------------------------------------------------
// s2d_back
// Converts one magnitude to packed decimal by shift-and-add-3, then sends the
// sign and the digits, leading zeros dropped, through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module s2d_back #(
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned MAX_CHARS  = 11
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     item_valid_i,
  output logic                          item_ready_o,
  input  wire logic                     item_neg_i,
  input  wire logic    [VALUE_BITS-1:0] item_mag_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic [s2d_pkg::CHAR_W-1:0]    out_char_o,
  output logic                          out_last_o
);
  import s2d_pkg::*;

  // enough digits for 2^VALUE_BITS, since log10(2) lies just above 0.3
  localparam int unsigned NDIG   = (VALUE_BITS * 3) / 10 + 1;
  localparam int unsigned BCD_W  = NDIG * 4;
  localparam int unsigned CNT_W  = $clog2(VALUE_BITS + 1);
  localparam int unsigned DIG_W  = $clog2(NDIG + 1);
  localparam int unsigned EMIT_W = $clog2(MAX_CHARS + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CONV  = 2'd1;
  localparam logic [1:0] ST_SIGN  = 2'd2;
  localparam logic [1:0] ST_DIGIT = 2'd3;

  logic [1:0]            state_q,    state_d;
  logic [VALUE_BITS-1:0] mag_q,      mag_d;
  logic                  neg_q,      neg_d;
  logic [BCD_W-1:0]      bcd_q,      bcd_d;
  logic [CNT_W-1:0]      bit_cnt_q,  bit_cnt_d;
  logic [DIG_W-1:0]      dig_left_q, dig_left_d;
  logic [EMIT_W-1:0]     emitted_q,  emitted_d;
  logic                  started_q,  started_d;
  logic                  out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]     out_char_q, out_char_d;
  logic                  out_last_q, out_last_d;

  logic [BCD_W-1:0]      bcd_adj;
  logic [3:0]            top_digit;
  logic                  slot_free;
  logic                  is_last;
  logic                  take;

  // add 3 to every digit of 5 or more before the next shift
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      bcd_adj[i*4 +: 4] = (bcd_q[i*4 +: 4] >= 4'd5) ? bcd_q[i*4 +: 4] + 4'd3
                                                    : bcd_q[i*4 +: 4];
    end
  end

  assign top_digit    = bcd_q[BCD_W-1 -: 4];
  assign slot_free    = !out_valid_q || out_ready_i;
  assign item_ready_o = (state_q == ST_IDLE);
  assign take         = item_valid_i && item_ready_o;
  assign is_last      = (dig_left_q == DIG_W'(1)) || (emitted_q == EMIT_W'(MAX_CHARS - 1));

  always_comb begin
    state_d     = state_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    bcd_d       = bcd_q;
    bit_cnt_d   = bit_cnt_q;
    dig_left_d  = dig_left_q;
    emitted_d   = emitted_q;
    started_d   = started_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;

    case (state_q)
      ST_IDLE: begin
        if (take) begin
          mag_d     = item_mag_i;
          neg_d     = item_neg_i;
          bcd_d     = '0;
          bit_cnt_d = CNT_W'(VALUE_BITS);
          state_d   = ST_CONV;
        end
      end
      ST_CONV: begin
        bcd_d     = {bcd_adj[BCD_W-2:0], mag_q[VALUE_BITS-1]};
        mag_d     = {mag_q[VALUE_BITS-2:0], 1'b0};
        bit_cnt_d = bit_cnt_q - CNT_W'(1);
        if (bit_cnt_q == CNT_W'(1)) begin
          dig_left_d = DIG_W'(NDIG);
          emitted_d  = '0;
          started_d  = 1'b0;
          state_d    = neg_q ? ST_SIGN : ST_DIGIT;
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_char_d  = ASCII_MINUS;
          out_last_d  = 1'b0;
          emitted_d   = EMIT_W'(1);
          state_d     = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (!started_q && top_digit == 4'd0 && dig_left_q != DIG_W'(1)) begin
          // leading zero
          bcd_d      = {bcd_q[BCD_W-5:0], 4'd0};
          dig_left_d = dig_left_q - DIG_W'(1);
        end else if (slot_free) begin
          out_valid_d = 1'b1;
          out_char_d  = ASCII_ZERO + {3'b000, top_digit};
          out_last_d  = is_last;
          if (is_last) begin
            state_d = ST_IDLE;
          end else begin
            bcd_d      = {bcd_q[BCD_W-5:0], 4'd0};
            dig_left_d = dig_left_q - DIG_W'(1);
            emitted_d  = emitted_q + EMIT_W'(1);
            started_d  = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bit_cnt_q   <= '0;
      dig_left_q  <= '0;
      emitted_q   <= '0;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bit_cnt_q   <= bit_cnt_d;
      dig_left_q  <= dig_left_d;
      emitted_q   <= emitted_d;
      started_q   <= started_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q      <= mag_d;
    neg_q      <= neg_d;
    bcd_q      <= bcd_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;

  a_take_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> (state_q == ST_CONV && bit_cnt_q == CNT_W'(VALUE_BITS)))
    else $error("request taken without starting conversion");

  a_digits_left : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIGIT) |-> (dig_left_q != '0))
    else $error("digit phase with no digits left");

  a_emit_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emitted_q < EMIT_W'(MAX_CHARS))
    else $error("character count beyond limit");

  a_sign_neg : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SIGN) |-> neg_q)
    else $error("sign phase for a non-negative value");

endmodule : s2d_back

`default_nettype wire

FILE: hw/rtl/signed_binary_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii
// Turns each signed integer into its decimal ASCII text, one character per
// output request, most significant first, tlast on the final character.
// ----------------------------------------------------------------------------
//  channel  | direction | tdata                        | tlast
//  s_axis   | in        | value (VALUE_BITS, signed)   | -
//  m_axis   | out       | character [6:0], zero [7]    | last_char
//
//  an item is loaded into the conversion engine, which runs one shift-and-add-3
//  step per magnitude bit, then drops each leading zero and sends each
//  character in turn, most significant first.
//  the two-entry input queue takes new values while the engine is busy.
//  the output register holds each character until taken; the next one waits.
//  reset clears the queue, the engine state and the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_binary_to_decimal_ascii #(
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned MAX_CHARS  = 11
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  // [VALUE_BITS-1:0] value, zero padding above
  input  wire logic [((VALUE_BITS + 7) / 8) * 8-1:0] s_axis_tdata,
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // [6:0] character, [7] zero
  output logic [s2d_pkg::OUT_DATA_W-1:0]            m_axis_tdata,
  output logic                                      m_axis_tlast
);
  import s2d_pkg::*;

  logic                  item_valid;
  logic                  item_ready;
  logic                  item_neg;
  logic [VALUE_BITS-1:0] item_mag;
  logic [CHAR_W-1:0]     out_char;

  s2d_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .value_i      (s_axis_tdata[VALUE_BITS-1:0]),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_neg_o   (item_neg),
    .item_mag_o   (item_mag)
  );

  s2d_back #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_CHARS  (MAX_CHARS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .item_neg_i   (item_neg),
    .item_mag_i   (item_mag),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_char_o   (out_char),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {(OUT_DATA_W - CHAR_W)'(0), out_char};

endmodule : signed_binary_to_decimal_ascii

`default_nettype wire
